@@ sv/occupancy_grid_ray_update_top_macros.svh @@
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_top_macros.svh
// Assertion macros for the occupancy grid ray update block.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RAY_UPDATE_TOP_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during rst
`define OGRU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ogru assertion failed");

// next-cycle implication
`define OGRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ogru assertion failed");

`else

`define OGRU_ASSERT_SAME(lbl, ante, cons)
`define OGRU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/ogru_pkg.sv @@
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared constants, types and helpers of the occupancy grid ray update block.
// ----------------------------------------------------------------------------
package ogru_pkg;

  localparam int GRID_SIDE  = 512;
  localparam int COORD_W    = 9;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int ERR_W      = COORD_W + 2;
  localparam int COUNT_W    = 9;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
  localparam logic [1:0] CELL_FREE     = 2'd1;
  localparam logic [1:0] CELL_OCCUPIED = 2'd2;

  localparam logic REQ_RAY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [COUNT_W-1:0] CLEAR_MAX = '1;

  // line parameters, fixed for the whole walk
  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               sx_neg;
    logic               sy_neg;
  } line_t;

  // walk position and error term
  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [ERR_W-1:0] err;
  } walk_t;

  function automatic logic coord_in_grid(input logic [COORD_W-1:0] c);
    return 32'(c) < GRID_SIDE;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] row);
    return {row, col};
  endfunction

endpackage

@@ sv/ogru_grid_ram.sv @@
// ----------------------------------------------------------------------------
// ogru_grid_ram
// Grid cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ogru_grid_ram
  import ogru_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [1:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [1:0]        rd_data
);

  logic [1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/ogru_step.sv @@
// ----------------------------------------------------------------------------
// ogru_step
// Bresenham step unit: next position and error term from the current ones.
// ----------------------------------------------------------------------------
module ogru_step
  import ogru_pkg::*;
(
  input  line_t ln,
  input  walk_t cur,
  output walk_t nxt
);

  logic signed [ERR_W-1:0] dx_s;
  logic signed [ERR_W-1:0] dy_s;
  logic                    step_x;
  logic                    step_y;
  logic signed [ERR_W-1:0] err_dec;
  logic signed [ERR_W-1:0] err_inc;

  assign dx_s = signed'({2'b00, ln.dx});
  assign dy_s = signed'({2'b00, ln.dy});

  // both tests use the error term from before this step
  assign step_x = cur.err > -dx_s;
  assign step_y = cur.err < dy_s;

  assign err_dec = step_x ? dy_s : '0;
  assign err_inc = step_y ? dx_s : '0;

  always_comb begin
    nxt.err = cur.err - err_dec + err_inc;
    nxt.x   = cur.x;
    nxt.y   = cur.y;
    if (step_x) begin
      nxt.x = ln.sx_neg ? cur.x - COORD_W'(1) : cur.x + COORD_W'(1);
    end
    if (step_y) begin
      nxt.y = ln.sy_neg ? cur.y - COORD_W'(1) : cur.y + COORD_W'(1);
    end
  end

endmodule

@@ sv/occupancy_grid_ray_update_top.sv @@
// Read item: S_RQ (issue read), then S_RQW (capture data), then S_DONE to the output register.
// Ray item: S_SETUP, then for each walked cell S_WALK (read), then S_CHK (check, write back and
// step), then S_MARK and S_DONE. Either kind: the next item is taken once its result has moved out.
// A result still held by m_axis_tready low keeps the following item in its final state.
// Reset: synchronous; afterwards a clearing pass writes every cell unknown, one per
// cycle, all GRID_SIDE*GRID_SIDE (262144) cells, with s_axis_tready low meanwhile.
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_top
// Occupancy grid kept in a block memory. Ray items walk the Bresenham line from
// start to end, turning unknown cells free, stopping at an occupied cell, and
// marking the end cell occupied. Read items return one cell's state.
// ----------------------------------------------------------------------------
`include "occupancy_grid_ray_update_top_macros.svh"

module occupancy_grid_ray_update_top
  import ogru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request item
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [8:0] start_x, [17:9] start_y, [26:18] end_x, [35:27] end_y, [39:36] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                  s_axis_tuser,
  // result item
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] cell_state, [2] ray_blocked, [11:3] cells_cleared, [15:12] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;  // post-reset sweep
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;  // deltas, directions, initial error
  localparam logic [3:0] S_WALK  = 4'd3;  // end test, issue cell read
  localparam logic [3:0] S_CHK   = 4'd4;  // check cell, write back, step
  localparam logic [3:0] S_MARK  = 4'd5;  // end cell -> occupied
  localparam logic [3:0] S_RQ    = 4'd6;  // read item: issue read
  localparam logic [3:0] S_RQW   = 4'd7;  // read item: capture data
  localparam logic [3:0] S_DONE  = 4'd8;  // hand result to output register

  logic [3:0]         state;
  logic [ADDR_W-1:0]  clr_addr;

  // latched request
  logic [COORD_W-1:0] ax;
  logic [COORD_W-1:0] ay;
  logic [COORD_W-1:0] bx;
  logic [COORD_W-1:0] by;

  // walk state
  line_t              ln;
  walk_t              cur;
  walk_t              nxt;

  // working result
  logic [1:0]         res_state;
  logic               res_blocked;
  logic [COUNT_W-1:0] res_cleared;

  // output register
  logic               out_valid;
  logic [1:0]         out_state;
  logic               out_blocked;
  logic [COUNT_W-1:0] out_cleared;

  // memory ports
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [1:0]         wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [1:0]         rd_data;

  // setup arithmetic
  logic               gx;
  logic               gy;
  logic [COORD_W-1:0] dx0;
  logic [COORD_W-1:0] dy0;
  logic signed [ERR_W-1:0] err0;
  logic               at_end;
  logic               room;

  // request fields straight off the bus
  logic               in_kind;
  logic [COORD_W-1:0] in_ax;
  logic [COORD_W-1:0] in_ay;
  logic [COORD_W-1:0] in_bx;
  logic [COORD_W-1:0] in_by;

  assign in_kind = s_axis_tuser;
  assign in_ax   = s_axis_tdata[COORD_W-1:0];
  assign in_ay   = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_bx   = s_axis_tdata[3*COORD_W-1:2*COORD_W];
  assign in_by   = s_axis_tdata[4*COORD_W-1:3*COORD_W];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - COUNT_W - 3)'(0), out_cleared, out_blocked, out_state};

  // line setup; direction is negative unless the end is strictly greater
  assign gx   = bx > ax;
  assign gy   = by > ay;
  assign dx0  = gx ? bx - ax : ax - bx;
  assign dy0  = gy ? by - ay : ay - by;
  assign err0 = (dx0 > dy0) ? signed'({2'b00, dx0 >> 1})
                            : -signed'({2'b00, dy0 >> 1});

  assign at_end = (cur.x == bx) && (cur.y == by);
  assign room   = !out_valid || m_axis_tready;

  ogru_step u_step (
    .ln  (ln),
    .cur (cur),
    .nxt (nxt)
  );

  ogru_grid_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cell_addr(cur.x, cur.y);
    wr_data = CELL_FREE;
    rd_en   = (state == S_WALK) || (state == S_RQ);
    rd_addr = (state == S_RQ) ? cell_addr(bx, by) : cell_addr(cur.x, cur.y);
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = CELL_UNKNOWN;
      end
      S_CHK: begin
        wr_en   = (rd_data == CELL_UNKNOWN);
      end
      S_MARK: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(bx, by);
        wr_data = CELL_OCCUPIED;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  // output register valid: set when a result moves in, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && room) begin
      out_valid <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (in_kind == REQ_READ) begin
              state <= (coord_in_grid(in_bx) && coord_in_grid(in_by)) ? S_RQ : S_DONE;
            end else begin
              state <= (coord_in_grid(in_ax) && coord_in_grid(in_ay) &&
                        coord_in_grid(in_bx) && coord_in_grid(in_by)) ? S_SETUP : S_DONE;
            end
          end
        end
        S_SETUP: begin
          state <= S_WALK;
        end
        S_WALK: begin
          state <= at_end ? S_MARK : S_CHK;
        end
        S_CHK: begin
          state <= (rd_data == CELL_OCCUPIED) ? S_MARK : S_WALK;
        end
        S_MARK: begin
          state <= S_DONE;
        end
        S_RQ: begin
          state <= S_RQW;
        end
        S_RQW: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (room) begin
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ax          <= in_ax;
        ay          <= in_ay;
        bx          <= in_bx;
        by          <= in_by;
        res_state   <= CELL_UNKNOWN;
        res_blocked <= 1'b0;
        res_cleared <= '0;
      end
      S_SETUP: begin
        ln.dx   <= dx0;
        ln.dy   <= dy0;
        ln.sx_neg <= !gx;
        ln.sy_neg <= !gy;
        cur.x   <= ax;
        cur.y   <= ay;
        cur.err <= err0;
      end
      S_CHK: begin
        if (rd_data == CELL_OCCUPIED) begin
          res_blocked <= 1'b1;
        end else begin
          if (rd_data == CELL_UNKNOWN && res_cleared != CLEAR_MAX) begin
            res_cleared <= res_cleared + COUNT_W'(1);
          end
          cur <= nxt;
        end
      end
      S_MARK: begin
        res_state <= CELL_OCCUPIED;
      end
      S_RQW: begin
        res_state <= rd_data;
      end
      S_DONE: begin
        if (room) begin
          out_state   <= res_state;
          out_blocked <= res_blocked;
          out_cleared <= res_cleared;
        end
      end
      default: begin
      end
    endcase
  end

  // a blocked ray always ends by marking its end cell
  `OGRU_ASSERT_SAME(a_blocked_marks_end, out_valid && out_blocked, out_state == CELL_OCCUPIED)
  // cells are only ever cleared by rays, which report occupied
  `OGRU_ASSERT_SAME(a_cleared_is_ray, out_valid && (out_cleared != '0),
                    out_state == CELL_OCCUPIED)
  // code 3 never comes back from the grid once the sweep is done
  `OGRU_ASSERT_SAME(a_no_bad_code, (state == S_CHK) || (state == S_RQW), rd_data != 2'd3)
  // an occupied cell met on the walk goes straight to the end-cell write
  `OGRU_ASSERT_NEXT(a_stop_at_occupied, (state == S_CHK) && (rd_data == CELL_OCCUPIED),
                    (state == S_MARK) && res_blocked)

endmodule
